/* rtl/core/lra_pkg.sv */
package lra_pkg;

	localparam int CHANNELS_DEF = 256;
	localparam int PERSIST_DEF  = 3;

	// Run counters hold up to the largest persistence setting (15).
	localparam int RUN_W    = 4;
	localparam int THR_W    = 10;
	localparam int COUNT_W  = 16;
	localparam int PROD_W   = 26;
	localparam int LOSS_MUL = 1000;

	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [PROD_W-1:0]  prod_t;
	typedef logic [RUN_W-1:0]   run_t;

	typedef enum logic [1:0] {
		VERDICT_NONE     = 2'd0,
		VERDICT_DEGRADED = 2'd1,
		VERDICT_CLEAN    = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		EVENT_NONE  = 2'd0,
		EVENT_RAISE = 2'd1,
		EVENT_CLEAR = 2'd2
	} event_t;

	typedef struct packed {
		logic [7:0] channel;
		logic       channel_in_use;
		count_t     tx_count;
		count_t     rx_count;
	} period_t;

	typedef struct packed {
		logic   degraded_period;
		event_t alarm_event;
		logic   alarm_active;
	} result_t;

	typedef struct packed {
		verdict_t verdict;
		run_t     deg_run;
		run_t     clean_run;
		logic     flag;
	} ch_state_t;

	localparam ch_state_t STATE_RESET = '{
		verdict:   VERDICT_NONE,
		deg_run:   '0,
		clean_run: '0,
		flag:      1'b0
	};

endpackage

/* rtl/core/lra_stream_if.sv */
interface lra_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/lra_loss_cmp.sv */
module lra_loss_cmp (
	input  logic            clk,
	input  logic            en,
	input  lra_pkg::count_t tx_count,
	input  lra_pkg::count_t rx_count,
	input  lra_pkg::thr_t   threshold,
	output logic            degraded
);
	import lra_pkg::*;

	prod_t  loss_s1;
	prod_t  limit_s1;
	logic   lossy_s1;
	count_t diff;

	assign diff = tx_count - rx_count;

	// Products are registered; the compare runs in the next stage.
	always_ff @(posedge clk) begin
		if (en) begin
			lossy_s1 <= (tx_count != '0) && (rx_count <= tx_count);
			loss_s1  <= PROD_W'(diff) * PROD_W'(LOSS_MUL);
			limit_s1 <= PROD_W'(threshold) * PROD_W'(tx_count);
		end
	end

	assign degraded = lossy_s1 && (loss_s1 > limit_s1);

endmodule

/* rtl/core/lra_state_ram.sv */
module lra_state_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [ADDR_W-1:0]  rd_addr,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  lra_pkg::ch_state_t wr_data,
	output lra_pkg::ch_state_t rd_data
);
	import lra_pkg::*;

	ch_state_t          state_mem_q [DEPTH];
	logic [DEPTH-1:0]   entry_vld_q;
	ch_state_t          rd_q;
	logic               rd_vld_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic               fwd_vld_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	ch_state_t          fwd_data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= state_mem_q[rd_addr];
			if (wr_en) begin
				state_mem_q[wr_addr] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
			rd_addr_q   <= '0;
			fwd_vld_q   <= 1'b0;
			fwd_addr_q  <= '0;
			fwd_data_q  <= STATE_RESET;
		end else if (en) begin
			rd_vld_q   <= entry_vld_q[rd_addr];
			rd_addr_q  <= rd_addr;
			// Keep the write of this edge: the read issued alongside it sees stale data.
			fwd_vld_q  <= wr_en;
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
			if (wr_en) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == rd_addr_q)) begin
			rd_data = fwd_data_q;
		end else if (rd_vld_q) begin
			rd_data = rd_q;
		end else begin
			rd_data = STATE_RESET;
		end
	end

endmodule

/* rtl/core/loss_ratio_degrade_alarm.sv */
// Channel   Dir  Handshake      Payload
// period    in   valid/ready    channel, channel_in_use, tx_count, rx_count
// result    out  valid/ready    degraded_period, alarm_event, alarm_active
// config    in   we only        degrade_threshold
//
// One period per cycle unless a result stalls; each result is registered twice before output.
// The transfer edge registers the products and reads the channel's state RAM; the next edge
// compares, writes back (forwarding the previous write) and loads the result register.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// A stalled result holds the whole pipeline; period.ready follows result register space.
module loss_ratio_degrade_alarm #(
	parameter int CHANNELS        = lra_pkg::CHANNELS_DEF,
	parameter int PERSIST_PERIODS = lra_pkg::PERSIST_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          degrade_threshold_we,
	input  lra_pkg::thr_t degrade_threshold,
	lra_stream_if.sink    period,
	lra_stream_if.source  result
);
	import lra_pkg::*;

	localparam int Depth = (CHANNELS < 256) ? CHANNELS : 256;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int ChCmpW = 13;

	thr_t       thr_q;
	logic       adv;
	logic       in_xfer;
	logic       vld_s1;
	logic       in_range_s1;
	logic       in_use_s1;
	logic [AddrW-1:0] addr_s1;
	logic       degraded;
	ch_state_t  cur;
	ch_state_t  nxt;
	logic       wr_en;
	result_t    res;
	result_t    res_q;
	logic       out_vld_q;
	run_t       run_inc;
	logic [AddrW-1:0] in_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (degrade_threshold_we) begin
			thr_q <= degrade_threshold;
		end
	end

	assign adv          = !out_vld_q || result.ready;
	assign period.ready = adv;
	assign in_xfer      = period.valid && adv;
	assign in_addr      = AddrW'(period.data.channel);

	lra_loss_cmp u_cmp (
		.clk       (clk),
		.en        (adv),
		.tx_count  (period.data.tx_count),
		.rx_count  (period.data.rx_count),
		.threshold (thr_q),
		.degraded  (degraded)
	);

	lra_state_ram #(
		.DEPTH  (Depth),
		.ADDR_W (AddrW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_addr (in_addr),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (nxt),
		.rd_data (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_range_s1 <= ChCmpW'(period.data.channel) < ChCmpW'(CHANNELS);
			in_use_s1   <= period.data.channel_in_use;
			addr_s1     <= in_addr;
		end
	end

	always_comb begin
		nxt     = cur;
		wr_en   = 1'b0;
		run_inc = '0;
		res     = '{degraded_period: 1'b0, alarm_event: EVENT_NONE, alarm_active: 1'b0};
		if (vld_s1 && in_range_s1) begin
			if (!in_use_s1) begin
				res.alarm_active = cur.flag;
			end else if (thr_q == '0) begin
				wr_en           = 1'b1;
				nxt.flag        = 1'b0;
				res.alarm_event = EVENT_CLEAR;
			end else if (degraded) begin
				wr_en               = 1'b1;
				res.degraded_period = 1'b1;
				if (cur.verdict == VERDICT_NONE || cur.verdict == VERDICT_DEGRADED) begin
					run_inc = cur.deg_run + run_t'(1);
				end else begin
					run_inc = run_t'(1);
				end
				nxt.verdict = VERDICT_DEGRADED;
				nxt.deg_run = run_inc;
				if (run_inc >= run_t'(PERSIST_PERIODS)) begin
					nxt.deg_run     = '0;
					nxt.clean_run   = '0;
					nxt.flag        = 1'b1;
					res.alarm_event = EVENT_RAISE;
				end
			end else begin
				wr_en       = 1'b1;
				nxt.deg_run = '0;
				if (cur.verdict == VERDICT_NONE || cur.verdict == VERDICT_CLEAN) begin
					run_inc = cur.clean_run + run_t'(1);
				end else begin
					run_inc = run_t'(1);
				end
				nxt.verdict   = VERDICT_CLEAN;
				nxt.clean_run = run_inc;
				if (run_inc >= run_t'(PERSIST_PERIODS)) begin
					nxt.clean_run   = '0;
					nxt.flag        = 1'b0;
					res.alarm_event = EVENT_CLEAR;
				end
			end
			res.alarm_active = wr_en ? nxt.flag : cur.flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = res_q;

	a_raise_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (res_q.alarm_event == EVENT_RAISE) |-> res_q.alarm_active)
		else $error("raise reported without alarm set");

	a_clear_drops_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (res_q.alarm_event == EVENT_CLEAR) |-> !res_q.alarm_active)
		else $error("clear reported with alarm still set");

	a_degrade_needs_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && res_q.degraded_period |-> (thr_q != '0) && (res_q.alarm_event != EVENT_CLEAR))
		else $error("degraded period with zero threshold or with a clear");

	a_write_only_when_moving: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> vld_s1 && in_range_s1 && in_use_s1)
		else $error("state write without a live in-use period");

endmodule

/* tb/tb_loss_ratio_degrade_alarm.sv */
`timescale 1ns / 100ps

module tb_loss_ratio_degrade_alarm;
	import lra_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 200;
	localparam int SEG_ITEMS    = 200;

	// Tracks per-channel verdict, run lengths and alarm flag; holds expected alarm results.
	class degrade_tracker;
		verdict_t    verdict[CHANNELS_DEF];
		int unsigned deg_run[CHANNELS_DEF];
		int unsigned clean_run[CHANNELS_DEF];
		bit          flag[CHANNELS_DEF];
		thr_t        threshold;
		result_t     expected_alarms[$];
		int          failures;

		function new();
			foreach (verdict[i]) begin
				verdict[i]   = VERDICT_NONE;
				deg_run[i]   = 0;
				clean_run[i] = 0;
				flag[i]      = 1'b0;
			end
			threshold = '0;
			failures  = 0;
		endfunction

		function void set_threshold(thr_t v);
			threshold = v;
		endfunction

		function int outstanding();
			return expected_alarms.size();
		endfunction

		function void take_period(period_t p);
			result_t     r;
			int unsigned ch, tx, rx;
			bit          lossy;
			ch = p.channel;
			tx = p.tx_count;
			rx = p.rx_count;
			r.degraded_period = 1'b0;
			r.alarm_event     = EVENT_NONE;
			r.alarm_active    = 1'b0;
			if (ch >= CHANNELS_DEF) begin
				expected_alarms.push_back(r);
				return;
			end
			if (p.channel_in_use) begin
				if (threshold == 0) begin
					flag[ch] = 1'b0;
					r.alarm_event = EVENT_CLEAR;
				end else begin
					lossy = (tx != 0) && (rx <= tx) && ((tx - rx) * 1000 > threshold * tx);
					if (lossy) begin
						r.degraded_period = 1'b1;
						if (verdict[ch] == VERDICT_CLEAN)
							deg_run[ch] = 1;
						else
							deg_run[ch] = deg_run[ch] + 1;
						verdict[ch] = VERDICT_DEGRADED;
						if (deg_run[ch] >= PERSIST_DEF) begin
							deg_run[ch]   = 0;
							clean_run[ch] = 0;
							flag[ch]      = 1'b1;
							r.alarm_event = EVENT_RAISE;
						end
					end else begin
						deg_run[ch] = 0;
						if (verdict[ch] == VERDICT_DEGRADED)
							clean_run[ch] = 1;
						else
							clean_run[ch] = clean_run[ch] + 1;
						verdict[ch] = VERDICT_CLEAN;
						if (clean_run[ch] >= PERSIST_DEF) begin
							clean_run[ch] = 0;
							deg_run[ch]   = 0;
							flag[ch]      = 1'b0;
							r.alarm_event = EVENT_CLEAR;
						end
					end
				end
			end
			r.alarm_active = flag[ch];
			expected_alarms.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_alarms.size() == 0) begin
				failures++;
				$display("%0t: result with nothing outstanding, expected none, actual %p",
					$time, got);
				return;
			end
			want = expected_alarms.pop_front();
			if (got.degraded_period !== want.degraded_period) begin
				failures++;
				$display("%0t: degraded_period expected %0d actual %0d", $time,
					want.degraded_period, got.degraded_period);
			end
			if (got.alarm_event !== want.alarm_event) begin
				failures++;
				$display("%0t: alarm_event expected %0d actual %0d", $time,
					want.alarm_event, got.alarm_event);
			end
			if (got.alarm_active !== want.alarm_active) begin
				failures++;
				$display("%0t: alarm_active expected %0d actual %0d", $time,
					want.alarm_active, got.alarm_active);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic degrade_threshold_we = 1'b0;
	thr_t degrade_threshold = '0;
	bit   hold_kick = 1'b0;
	int   send_gap_pct = 0;
	int   recv_stall_pct = 0;

	degrade_tracker tracker = new();

	lra_stream_if #(.T(period_t)) period_if();
	lra_stream_if #(.T(result_t)) result_if();

	loss_ratio_degrade_alarm u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.degrade_threshold_we (degrade_threshold_we),
		.degrade_threshold    (degrade_threshold),
		.period               (period_if),
		.result               (result_if)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Transfers are decided by values stable at the falling edge.
	always @(negedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			tracker.check_result(result_if.data);
	end

	initial begin
		int  hold_left;
		bit  kick_seen;
		hold_left = 0;
		kick_seen = 1'b0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_kick != kick_seen) begin
				kick_seen = hold_kick;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic period_t period_of(int ch, bit used, int tx, int rx);
		period_t p;
		p.channel        = ch[7:0];
		p.channel_in_use = used;
		p.tx_count       = tx[15:0];
		p.rx_count       = rx[15:0];
		return p;
	endfunction

	// Called at a rising edge; returns at the rising edge of the transfer.
	task automatic send_period(input period_t p);
		bit took;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			period_if.valid <= 1'b0;
			@(posedge clk);
		end
		period_if.valid <= 1'b1;
		period_if.data  <= p;
		do begin
			@(negedge clk);
			took = period_if.ready;
			if (took)
				tracker.take_period(p);
			@(posedge clk);
		end while (!took);
	endtask

	task automatic drain();
		period_if.valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input int v);
		drain();
		degrade_threshold_we <= 1'b1;
		degrade_threshold    <= v[THR_W-1:0];
		tracker.set_threshold(v[THR_W-1:0]);
		@(posedge clk);
		degrade_threshold_we <= 1'b0;
	endtask

	// Bursts on a few hot channels so runs reach the persistence count.
	task automatic run_random(input int target);
		int          done, len, mode, k, pick;
		int unsigned tx, rx, thr, lim;
		period_t     p;
		done = 0;
		while (done < target) begin
			k = $urandom_range(0, 7);
			if (k == 7)
				p.channel = 8'($urandom_range(0, 255));
			else if (k == 6)
				p.channel = 8'hFF;
			else
				p.channel = 8'(k);
			len  = $urandom_range(1, 5);
			mode = $urandom_range(0, 9);
			repeat (len) begin
				p.channel_in_use = ($urandom_range(0, 15) != 0);
				pick = $urandom_range(0, 9);
				if (pick == 0)
					tx = 0;
				else if (pick == 1)
					tx = 65535;
				else if (pick < 5)
					tx = $urandom_range(1, 200);
				else
					tx = $urandom_range(1, 65535);
				thr = tracker.threshold;
				if (thr > 1000)
					thr = 1000;
				lim = tx * (1000 - thr) / 1000;
				if ($urandom_range(0, 11) == 0)
					rx = $urandom_range(0, 65535);
				else if (mode < 4)
					rx = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
				else if (mode < 8)
					rx = $urandom_range(0, 1) ? $urandom_range(lim, tx) : $urandom_range(lim, 65535);
				else begin
					rx = lim + $urandom_range(0, 2);
					rx = (rx == 0) ? 0 : rx - 1;
					if (rx > 65535)
						rx = 65535;
				end
				p.tx_count = tx[15:0];
				p.rx_count = rx[15:0];
				send_period(p);
				if (p.channel_in_use)
					done++;
			end
		end
	endtask

	initial begin
		period_if.valid = 1'b0;
		period_if.data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold zero out of reset: every in-use period clears
		send_period(period_of(0, 1, 65535, 0));
		send_period(period_of(255, 0, 0, 0));
		send_period(period_of(7, 1, 0, 65535));

		write_threshold(100);
		repeat (3) send_period(period_of(5, 1, 1000, 800));
		send_period(period_of(5, 0, 1000, 0));
		send_period(period_of(5, 1, 1000, 900));
		send_period(period_of(5, 1, 0, 0));
		send_period(period_of(5, 1, 10, 20));
		send_period(period_of(9, 1, 1000, 899));
		send_period(period_of(9, 1, 1000, 899));
		send_period(period_of(9, 1, 500, 600));
		send_period(period_of(9, 1, 1000, 0));

		// forced clear leaves the run counters where they were
		write_threshold(0);
		send_period(period_of(9, 1, 1000, 0));

		write_threshold(1);
		send_period(period_of(9, 1, 999, 998));
		send_period(period_of(9, 1, 1000, 999));
		send_period(period_of(9, 1, 65535, 65534));

		write_threshold(1000);
		send_period(period_of(3, 1, 65535, 0));
		write_threshold(1023);
		send_period(period_of(3, 1, 65535, 0));
		send_period(period_of(3, 1, 65535, 65535));
		send_period(period_of(128, 1, 43690, 21845));

		send_gap_pct   = 31;
		recv_stall_pct = 71;
		write_threshold(250);
		run_random(SEG_ITEMS);
		write_threshold(0);
		run_random(SEG_ITEMS);
		write_threshold(1);
		run_random(SEG_ITEMS);

		send_gap_pct   = 71;
		recv_stall_pct = 31;
		write_threshold($urandom_range(2, 999));
		run_random(SEG_ITEMS);
		write_threshold(1023);
		run_random(SEG_ITEMS);
		write_threshold(1000);
		run_random(SEG_ITEMS);

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		write_threshold($urandom_range(2, 999));
		// hold off the result side while periods keep coming
		hold_kick <= ~hold_kick;
		run_random(SEG_ITEMS);
		write_threshold(500);
		run_random(SEG_ITEMS);
		write_threshold(50);
		run_random(SEG_ITEMS);

		drain();
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("PASS loss_ratio_degrade_alarm");
		else
			$display("FAIL loss_ratio_degrade_alarm");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL loss_ratio_degrade_alarm");
		$finish;
	end

endmodule

/* files.f */
rtl/core/lra_pkg.sv
rtl/core/lra_stream_if.sv
rtl/core/lra_loss_cmp.sv
rtl/core/lra_state_ram.sv
rtl/core/loss_ratio_degrade_alarm.sv
tb/tb_loss_ratio_degrade_alarm.sv
